FILE: rtl/core/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared codes for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    typedef logic [1:0] t_case;

    localparam t_case CASE_X = 2'd0;
    localparam t_case CASE_Y = 2'd1;
    localparam t_case CASE_Z = 2'd2;
    localparam t_case CASE_W = 2'd3;

endpackage

FILE: rtl/core/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the largest diagonal combination and packs the
// radicand, the pick and the three off-diagonal magnitudes and signs.
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [DATA_WIDTH-1:0]        i_m00,
    input  logic signed [DATA_WIDTH-1:0]        i_m01,
    input  logic signed [DATA_WIDTH-1:0]        i_m02,
    input  logic signed [DATA_WIDTH-1:0]        i_m10,
    input  logic signed [DATA_WIDTH-1:0]        i_m11,
    input  logic signed [DATA_WIDTH-1:0]        i_m12,
    input  logic signed [DATA_WIDTH-1:0]        i_m20,
    input  logic signed [DATA_WIDTH-1:0]        i_m21,
    input  logic signed [DATA_WIDTH-1:0]        i_m22,
    input  logic                                i_full,
    output logic                                o_push,
    output logic [3*(DATA_WIDTH+1)+(((DATA_WIDTH>FRAC_BITS+1)?DATA_WIDTH:FRAC_BITS+1)
                  +FRAC_BITS)+6-1:0]            o_item
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int SW = DW + 2;
    localparam int CW = ((DW > FB + 1) ? DW : FB + 1) + 3;
    localparam int RW = CW - 1 + FB - 2;
    localparam int MW = DW + 1;
    localparam int IW = RW + 3 * MW + 6;

    logic signed [SW-1:0] cx, cy, cz, cw, best;
    logic signed [CW-1:0] rad;
    t_case                pick;
    logic                 ident;
    logic [RW-1:0]        radicand;
    logic signed [MW-1:0] s_a, s_b, s_c, d_x, d_y, d_z;
    logic signed [MW-1:0] lane [3];
    logic [MW-1:0]        mag [3];
    logic [2:0]           neg;
    logic [IW-1:0]        n_item;
    logic [IW-1:0]        r_item;
    logic                 r_vld;

    always_comb begin
        cx = SW'(i_m00) - SW'(i_m11) - SW'(i_m22);
        cy = SW'(i_m11) - SW'(i_m00) - SW'(i_m22);
        cz = SW'(i_m22) - SW'(i_m00) - SW'(i_m11);
        cw = SW'(i_m00) + SW'(i_m11) + SW'(i_m22);
        best = cw;
        pick = CASE_W;
        if (cx > best) begin
            best = cx;
            pick = CASE_X;
        end
        if (cy > best) begin
            best = cy;
            pick = CASE_Y;
        end
        if (cz > best) begin
            best = cz;
            pick = CASE_Z;
        end
        rad = CW'(best) + (CW'(1) << FB);
        ident = (rad <= 0);
        radicand = ident ? '0 : {rad[CW-2:0], {(FB-2){1'b0}}};

        s_a = MW'(i_m01) + MW'(i_m10);
        s_b = MW'(i_m20) + MW'(i_m02);
        s_c = MW'(i_m12) + MW'(i_m21);
        d_x = MW'(i_m12) - MW'(i_m21);
        d_y = MW'(i_m20) - MW'(i_m02);
        d_z = MW'(i_m01) - MW'(i_m10);

        unique case (pick)
            CASE_X: begin
                lane[0] = s_a; lane[1] = s_b; lane[2] = d_x;
            end
            CASE_Y: begin
                lane[0] = s_a; lane[1] = s_c; lane[2] = d_y;
            end
            CASE_Z: begin
                lane[0] = s_b; lane[1] = s_c; lane[2] = d_z;
            end
            default: begin
                lane[0] = d_x; lane[1] = d_y; lane[2] = d_z;
            end
        endcase

        for (int l = 0; l < 3; l++) begin
            neg[l] = lane[l][MW-1];
            mag[l] = neg[l] ? MW'(-lane[l]) : MW'(lane[l]);
        end

        n_item = {ident, pick, neg, mag[2], mag[1], mag[0], radicand};
    end

    assign o_stall = r_vld & i_full;
    assign o_push  = r_vld & ~i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/core/rmq_fifo.sv
// ----------------------------------------------------------------------------
// rmq_fifo
// Short flop queue between the front and the back.
// ----------------------------------------------------------------------------
module rmq_fifo
    import rmq_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW-1:0] == r_rd[AW-1:0]) && (r_wr[AW] != r_rd[AW]);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

FILE: rtl/core/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root and three pipelined dividers, then sign fix,
// saturation and component placement into the output register.
// ----------------------------------------------------------------------------
module rmq_back
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  logic [3*(DATA_WIDTH+1)+(((DATA_WIDTH>FRAC_BITS+1)?DATA_WIDTH:FRAC_BITS+1)
                  +FRAC_BITS)+6-1:0]     i_item,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_qx,
    output logic signed [DATA_WIDTH-1:0] o_qy,
    output logic signed [DATA_WIDTH-1:0] o_qz,
    output logic signed [DATA_WIDTH-1:0] o_qw,
    output logic [1:0]                   o_largest_case
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int CW = ((DW > FB + 1) ? DW : FB + 1) + 3;
    localparam int RW = CW - 1 + FB - 2;
    localparam int MW = DW + 1;
    localparam int GW = (RW + 1) / 2;
    localparam int NP = 2 * GW;
    localparam int NW = MW + FB - 2;
    localparam int XW = 3 * MW + 6;

    localparam logic [NW-1:0] QMAX = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [NW-1:0] QMIN = {{(NW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE_Q = (FB >= DW - 1) ? SMAX : (DW'(1) << FB);

    function automatic logic [DW-1:0] sat(input logic [NW-1:0] q, input logic n);
        logic [DW-1:0] res;
        if (n) begin
            res = (q >= QMIN) ? SMIN : DW'(-q);
        end else begin
            res = (q > QMAX) ? SMAX : DW'(q);
        end
        return res;
    endfunction

    logic en;

    logic            r_sq_vld  [GW+1];
    logic [NP-1:0]   r_sq_n    [GW+1];
    logic [GW-1:0]   r_sq_root [GW+1];
    logic [GW:0]     r_sq_rem  [GW+1];
    logic [XW-1:0]   r_sq_meta [GW+1];

    logic            r_dv_vld  [NW+1];
    logic [GW-1:0]   r_dv_g    [NW+1];
    logic [GW-1:0]   r_dv_rem  [NW+1][3];
    logic [NW-1:0]   r_dv_nq   [NW+1][3];
    logic [5:0]      r_dv_meta [NW+1];

    logic            r_out_vld;
    logic [DW-1:0]   r_qx, r_qy, r_qz, r_qw;
    t_case           r_case;

    assign en    = ~(r_out_vld & i_stall);
    assign o_pop = en & ~i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= ~i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_n[0]    <= NP'(i_item[RW-1:0]);
            r_sq_root[0] <= '0;
            r_sq_rem[0]  <= '0;
            r_sq_meta[0] <= i_item[RW +: XW];
        end
    end

    genvar k, l;
    generate
        for (k = 1; k <= GW; k++) begin : g_sq
            logic [GW+2:0] remx, trial;
            logic          ge;

            always_comb begin
                remx  = {r_sq_rem[k-1], r_sq_n[k-1][NP-1:NP-2]};
                trial = {1'b0, r_sq_root[k-1], 2'b01};
                ge    = (remx >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k] <= 1'b0;
                end else if (en) begin
                    r_sq_vld[k] <= r_sq_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_n[k]    <= {r_sq_n[k-1][NP-3:0], 2'b00};
                    r_sq_root[k] <= {r_sq_root[k-1][GW-2:0], ge};
                    r_sq_rem[k]  <= ge ? (GW+1)'(remx - trial) : (GW+1)'(remx);
                    r_sq_meta[k] <= r_sq_meta[k-1];
                end
            end
        end

        // stage 0 of the dividers is a view of the last root stage
        assign r_dv_vld[0]  = r_sq_vld[GW];
        assign r_dv_g[0]    = r_sq_root[GW];
        assign r_dv_meta[0] = r_sq_meta[GW][XW-1 -: 6];
        for (l = 0; l < 3; l++) begin : g_init
            assign r_dv_rem[0][l] = '0;
            assign r_dv_nq[0][l]  = {r_sq_meta[GW][l*MW +: MW], {(FB-2){1'b0}}};
        end

        for (k = 1; k <= NW; k++) begin : g_dv
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[k] <= 1'b0;
                end else if (en) begin
                    r_dv_vld[k] <= r_dv_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_g[k]    <= r_dv_g[k-1];
                    r_dv_meta[k] <= r_dv_meta[k-1];
                end
            end

            for (l = 0; l < 3; l++) begin : g_lane
                logic [GW:0] rem2;
                logic        ge;

                always_comb begin
                    rem2 = {r_dv_rem[k-1][l], r_dv_nq[k-1][l][NW-1]};
                    ge   = (rem2 >= {1'b0, r_dv_g[k-1]});
                end

                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dv_rem[k][l] <= ge ? GW'(rem2 - {1'b0, r_dv_g[k-1]}) : GW'(rem2);
                        r_dv_nq[k][l]  <= {r_dv_nq[k-1][l][NW-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    logic [DW-1:0] v0, v1, v2, vg;
    logic          f_ident;
    t_case         f_pick;
    logic [2:0]    f_neg;

    always_comb begin
        f_ident = r_dv_meta[NW][5];
        f_pick  = r_dv_meta[NW][4:3];
        f_neg   = r_dv_meta[NW][2:0];
        v0 = sat(r_dv_nq[NW][0], f_neg[0]);
        v1 = sat(r_dv_nq[NW][1], f_neg[1]);
        v2 = sat(r_dv_nq[NW][2], f_neg[2]);
        vg = sat(NW'(r_dv_g[NW]), 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (f_ident) begin
                r_qx   <= '0;
                r_qy   <= '0;
                r_qz   <= '0;
                r_qw   <= ONE_Q;
                r_case <= CASE_W;
            end else begin
                r_case <= f_pick;
                unique case (f_pick)
                    CASE_X: begin
                        r_qx <= vg; r_qy <= v0; r_qz <= v1; r_qw <= v2;
                    end
                    CASE_Y: begin
                        r_qx <= v0; r_qy <= vg; r_qz <= v1; r_qw <= v2;
                    end
                    CASE_Z: begin
                        r_qx <= v0; r_qy <= v1; r_qz <= vg; r_qw <= v2;
                    end
                    default: begin
                        r_qx <= v0; r_qy <= v1; r_qz <= v2; r_qw <= vg;
                    end
                endcase
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_qx           = r_qx;
    assign o_qy           = r_qy;
    assign o_qz           = r_qz;
    assign o_qw           = r_qw;
    assign o_largest_case = r_case;

endmodule

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix to a unit quaternion by picking the largest
// diagonal combination, taking a root and dividing the off-diagonal terms.
//
// Input channel: i_valid / o_stall with the nine entries i_m00..i_m22.
// Output channel: o_valid / i_stall with o_qx..o_qw and o_largest_case.
// A transaction completes on a clock edge with valid high and stall low.
// One matrix is accepted every cycle while o_stall is low; one result leaves per matrix, in order.
// The pipeline has GW root stages (one result bit each, GW = half the radicand
// width, 15 at the defaults) and NW divider stages (one quotient bit each,
// DATA_WIDTH + FRAC_BITS - 1, 29 at the defaults).
// When the receiver stalls, the back pipeline holds, the four-entry queue
// fills, and then o_stall rises. Reset empties the pipeline and the queue.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_m00,
    input  logic signed [DATA_WIDTH-1:0] i_m01,
    input  logic signed [DATA_WIDTH-1:0] i_m02,
    input  logic signed [DATA_WIDTH-1:0] i_m10,
    input  logic signed [DATA_WIDTH-1:0] i_m11,
    input  logic signed [DATA_WIDTH-1:0] i_m12,
    input  logic signed [DATA_WIDTH-1:0] i_m20,
    input  logic signed [DATA_WIDTH-1:0] i_m21,
    input  logic signed [DATA_WIDTH-1:0] i_m22,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_qx,
    output logic signed [DATA_WIDTH-1:0] o_qy,
    output logic signed [DATA_WIDTH-1:0] o_qz,
    output logic signed [DATA_WIDTH-1:0] o_qw,
    output logic [1:0]                   o_largest_case
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int CW = ((DW > FB + 1) ? DW : FB + 1) + 3;
    localparam int RW = CW - 1 + FB - 2;
    localparam int IW = RW + 3 * (DW + 1) + 6;

    logic          push, pop, full, empty;
    logic [IW-1:0] f_item, q_item;

    rmq_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    rmq_fifo #(
        .WIDTH (IW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_item)
    );

    rmq_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_item         (q_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_qx           (o_qx),
        .o_qy           (o_qy),
        .o_qz           (o_qz),
        .o_qw           (o_qw),
        .o_largest_case (o_largest_case)
    );

endmodule

FILE: test/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both channels of the matrix to quaternion block, predicts each
// quaternion from the accepted matrix and compares it in order with the output.
// ----------------------------------------------------------------------------
module rmq_checker
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_m00,
    input  logic signed [DATA_WIDTH-1:0] i_m01,
    input  logic signed [DATA_WIDTH-1:0] i_m02,
    input  logic signed [DATA_WIDTH-1:0] i_m10,
    input  logic signed [DATA_WIDTH-1:0] i_m11,
    input  logic signed [DATA_WIDTH-1:0] i_m12,
    input  logic signed [DATA_WIDTH-1:0] i_m20,
    input  logic signed [DATA_WIDTH-1:0] i_m21,
    input  logic signed [DATA_WIDTH-1:0] i_m22,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic signed [DATA_WIDTH-1:0] i_qx,
    input  logic signed [DATA_WIDTH-1:0] i_qy,
    input  logic signed [DATA_WIDTH-1:0] i_qz,
    input  logic signed [DATA_WIDTH-1:0] i_qw,
    input  logic [1:0]                   i_largest_case,
    output int                           o_errors,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] qx, qy, qz, qw;
        t_case                        lc;
    } t_quat;

    t_quat quat_queue[$];

    function automatic logic signed [DATA_WIDTH-1:0] sat(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return DATA_WIDTH'(v);
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) <<< b)) * (r + (longint'(1) <<< b)) <= n)
                r += longint'(1) <<< b;
        end
        return r;
    endfunction

    function automatic longint scale_div(longint s, longint g);
        longint m;
        m = ((s < 0) ? -s : s) <<< (FRAC_BITS - 2);
        return (s < 0) ? -(m / g) : (m / g);
    endfunction

    function automatic t_quat matrix_to_quat(longint a00, a01, a02, a10, a11,
                                             a12, a20, a21, a22);
        t_quat  q;
        longint best, rad, g, sxy, sxz, syz, dx, dy, dz;
        t_case  pick;
        best = a00 + a11 + a22;
        pick = CASE_W;
        if (a00 - a11 - a22 > best) begin best = a00 - a11 - a22; pick = CASE_X; end
        if (a11 - a00 - a22 > best) begin best = a11 - a00 - a22; pick = CASE_Y; end
        if (a22 - a00 - a11 > best) begin best = a22 - a00 - a11; pick = CASE_Z; end
        rad = best + (longint'(1) <<< FRAC_BITS);
        if (rad <= 0) begin
            q.qx = '0; q.qy = '0; q.qz = '0;
            q.qw = sat(longint'(1) <<< FRAC_BITS);
            q.lc = CASE_W;
            return q;
        end
        g = root_floor(rad <<< (FRAC_BITS - 2));
        sxy = scale_div(a01 + a10, g);
        sxz = scale_div(a20 + a02, g);
        syz = scale_div(a12 + a21, g);
        dx  = scale_div(a12 - a21, g);
        dy  = scale_div(a20 - a02, g);
        dz  = scale_div(a01 - a10, g);
        case (pick)
            CASE_X: begin q.qx = sat(g); q.qy = sat(sxy); q.qz = sat(sxz); q.qw = sat(dx); end
            CASE_Y: begin q.qx = sat(sxy); q.qy = sat(g); q.qz = sat(syz); q.qw = sat(dy); end
            CASE_Z: begin q.qx = sat(sxz); q.qy = sat(syz); q.qz = sat(g); q.qw = sat(dz); end
            default: begin q.qx = sat(dx); q.qy = sat(dy); q.qz = sat(dz); q.qw = sat(g); end
        endcase
        q.lc = pick;
        return q;
    endfunction

    initial o_errors = 0;
    assign o_pending = quat_queue.size();

    always @(posedge i_clk) begin
        t_quat want;
        int    bad;
        bad = 0;
        if (i_rst_n && i_valid && !i_in_stall)
            quat_queue.push_back(matrix_to_quat(i_m00, i_m01, i_m02, i_m10, i_m11,
                                                i_m12, i_m20, i_m21, i_m22));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (quat_queue.size() == 0) begin
                $error("unexpected quaternion transaction");
                bad++;
            end else begin
                want = quat_queue.pop_front();
                if (i_qx !== want.qx) begin
                    $error("qx expected %0d actual %0d", want.qx, i_qx);
                    bad++;
                end
                if (i_qy !== want.qy) begin
                    $error("qy expected %0d actual %0d", want.qy, i_qy);
                    bad++;
                end
                if (i_qz !== want.qz) begin
                    $error("qz expected %0d actual %0d", want.qz, i_qz);
                    bad++;
                end
                if (i_qw !== want.qw) begin
                    $error("qw expected %0d actual %0d", want.qw, i_qw);
                    bad++;
                end
                if (i_largest_case !== want.lc) begin
                    $error("largest_case expected %0d actual %0d", want.lc, i_largest_case);
                    bad++;
                end
            end
        end
        if (bad != 0) begin
            o_errors <= o_errors + bad;
        end
    end
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives matrices into the quaternion block with bursty input and a stalling
// receiver, including one long hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW        = 16;
    localparam int N_RANDOM  = 680;
    localparam int LATENCY   = 48;
    localparam longint LIMIT = 400000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic signed [DW-1:0] m [9];
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic signed [DW-1:0] qx, qy, qz, qw;
    logic [1:0]    largest_case;
    int            errors, pending;
    longint        cycles = 0;
    bit            holdoff_done = 1'b0;
    bit            holdoff_go = 1'b0;

    initial foreach (m[k]) m[k] = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rotation_matrix_to_quaternion dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_m00(m[0]), .i_m01(m[1]), .i_m02(m[2]), .i_m10(m[3]), .i_m11(m[4]),
        .i_m12(m[5]), .i_m20(m[6]), .i_m21(m[7]), .i_m22(m[8]),
        .o_valid(out_valid), .i_stall(out_stall), .o_qx(qx), .o_qy(qy), .o_qz(qz),
        .o_qw(qw), .o_largest_case(largest_case)
    );

    rmq_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_m00(m[0]), .i_m01(m[1]), .i_m02(m[2]), .i_m10(m[3]), .i_m11(m[4]),
        .i_m12(m[5]), .i_m20(m[6]), .i_m21(m[7]), .i_m22(m[8]),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_qx(qx), .i_qy(qy),
        .i_qz(qz), .i_qw(qw), .i_largest_case(largest_case),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall pattern with stall-free windows, one long hold-off
    always @(posedge clk) begin
        int hold;
        if (holdoff_go && !holdoff_done) begin
            out_stall <= 1'b1;
            for (hold = 0; hold < 200; hold++) @(posedge clk);
            out_stall <= 1'b0;
            holdoff_done = 1'b1;
        end else if (cycles[9:8] == 2'd1) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_matrix(input logic signed [DW-1:0] v [9]);
        in_valid <= 1'b1;
        foreach (m[k]) m[k] <= v[k];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic rotation_like(output logic signed [DW-1:0] v [9]);
        int axis, s;
        axis = $urandom_range(0, 3);
        foreach (v[k]) v[k] = $signed(DW'($urandom_range(0, 8192))) - 16'sd4096;
        s = ($urandom_range(0, 1) ? 16384 : -16384);
        if (axis < 3) begin
            v[axis * 4] = 16'(16384 - $urandom_range(0, 2048));
            v[((axis + 1) % 3) * 4] = 16'(s - ($urandom_range(0, 1) ? 1 : 0) * s / 2);
            v[((axis + 2) % 3) * 4] = 16'(-s / 2 + $urandom_range(0, 4096));
        end else begin
            v[0] = 16'(16384 - $urandom_range(0, 4096));
            v[4] = 16'(16384 - $urandom_range(0, 4096));
            v[8] = 16'(16384 - $urandom_range(0, 4096));
        end
    endtask

    initial begin
        logic signed [DW-1:0] v [9];
        int burst;
        int gap;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, ties and each pick
        for (int d = 0; d < 20; d++) begin
            foreach (v[k]) v[k] = '0;
            case (d)
                0: ;
                1: foreach (v[k]) v[k] = 16'sh7fff;
                2: foreach (v[k]) v[k] = 16'sh8000;
                3: foreach (v[k]) v[k] = (k % 2) ? 16'sh7fff : 16'sh8000;
                4: foreach (v[k]) v[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
                5: begin v[0] = 16384; v[4] = 16384; v[8] = 16384; end
                6: begin v[0] = 16384; v[4] = -16384; v[8] = -16384; end
                7: begin v[0] = -16384; v[4] = 16384; v[8] = -16384; end
                8: begin v[0] = -16384; v[4] = -16384; v[8] = 16384; end
                9: begin v[0] = 100; v[4] = 100; v[8] = 100; end
                10: begin v[0] = -5461; v[4] = -5461; v[8] = -5462; end
                11: begin v[0] = 16'sh8000; v[4] = 16'sh8000; v[8] = 16'sh8000; end
                12: begin v[0] = 16'sh8000; v[4] = 16'sh7fff; v[8] = 16'sh7fff;
                          v[1] = 16'sh7fff; v[3] = 16'sh7fff; end
                13: begin v[0] = 16'sh7fff; v[4] = 16'sh8000; v[8] = 16'sh8000;
                          v[5] = 16'sh8000; v[7] = 16'sh7fff; end
                14: begin v[8] = 16'sh7fff; v[2] = 16'sh8000; v[6] = 16'sh8000; end
                15: begin v[0] = -16384; v[4] = -16384; v[8] = -16384; end
                16: begin v[0] = 0; v[4] = -8192; v[8] = -8192; end
                17: foreach (v[k]) v[k] = 16'(16'h5555 << (k % 2));
                18: foreach (v[k]) v[k] = 16'shffff;
                19: foreach (v[k]) v[k] = 16'sh0001;
            endcase
            send_matrix(v);
        end

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                if ($urandom_range(0, 9) < 7) rotation_like(v);
                else foreach (v[k]) v[k] = DW'($urandom);
                if (n == 200) holdoff_go = 1'b1;
                send_matrix(v);
            end
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_fifo.sv
rtl/core/rmq_back.sv
rtl/core/rotation_matrix_to_quaternion.sv
test/rmq_checker.sv
test/tb.sv
